@@ src/tcce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared widths, character codes, item kinds and the command and status
// structs between the console controller and its datapath.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int unsigned MAX_COLS_DEF = 80;
    localparam int unsigned MAX_ROWS_DEF = 25;

    localparam int unsigned COL_W     = 7;
    localparam int unsigned ROW_W     = 5;
    localparam int unsigned LIN_W     = COL_W + ROW_W;
    localparam int unsigned LINEAR_W  = 11;
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned COLOR_W   = 4;
    localparam int unsigned CFG_W     = 7;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned TAB_W     = 2;

    localparam int unsigned SCREEN_COLS_RESET = 80;
    localparam int unsigned SCREEN_ROWS_RESET = 25;
    localparam int unsigned TAB_SPACES        = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 1'd1;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

    localparam logic [KIND_W-1:0] KIND_READ = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NUL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAB  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LF   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CR   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_BS   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CHAR = 3'd6;

    typedef struct packed {
        logic load_item;
        logic clear_wr;
        logic cap_cell;
        logic col_zero;
        logic row_inc;
        logic back_step;
        logic write_cell;
        logic advance;
        logic scroll_start;
        logic scroll_rd;
        logic scroll_wr;
        logic out_load;
    } tcce_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              rd_ok;
        logic              last_col;
        logic              last_row;
        logic              clr_last;
        logic              scr_last;
        logic              out_free;
    } tcce_status_t;

endpackage
`default_nettype wire

@@ src/tcce_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_datapath
// Cell memory, geometry registers, cursor, scroll and clear counters and the
// output word register of the text console.
// ----------------------------------------------------------------------------
module tcce_datapath #(
    parameter int unsigned MAX_COLS = tcce_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = tcce_pkg::MAX_ROWS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [tcce_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tcce_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic                               s_action,
    input  wire logic [tcce_pkg::CHAR_W-1:0]        s_char_code,
    input  wire logic [tcce_pkg::COLOR_W-1:0]       s_fg_color,
    input  wire logic [tcce_pkg::COLOR_W-1:0]       s_bg_color,
    input  wire logic [tcce_pkg::COL_W-1:0]         s_read_col,
    input  wire logic [tcce_pkg::ROW_W-1:0]         s_read_row,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [tcce_pkg::COL_W-1:0]              m_cursor_col,
    output logic [tcce_pkg::ROW_W-1:0]              m_cursor_row,
    output logic [tcce_pkg::LINEAR_W-1:0]           m_cursor_linear,
    output logic [tcce_pkg::CELL_W-1:0]             m_cell_value,
    output logic                                    m_did_scroll,
    input  wire tcce_pkg::tcce_cmd_t                cmd,
    output tcce_pkg::tcce_status_t                  status
);
    import tcce_pkg::*;

    localparam int unsigned DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [COL_W-1:0] COLS_RST =
        COL_W'((MAX_COLS < SCREEN_COLS_RESET) ? MAX_COLS : SCREEN_COLS_RESET);
    localparam logic [ROW_W-1:0] ROWS_RST =
        ROW_W'((MAX_ROWS < SCREEN_ROWS_RESET) ? MAX_ROWS : SCREEN_ROWS_RESET);

    logic [CELL_W-1:0] cell_mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    logic [COL_W-1:0]   cols_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [LIN_W-1:0]   sa_reg;

    logic               act_reg;
    logic [CHAR_W-1:0]  ch_reg;
    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [COL_W-1:0]   rc_reg;
    logic [ROW_W-1:0]   rr_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic               scrolled_reg;

    logic                m_valid_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [LINEAR_W-1:0] out_lin_reg;
    logic [CELL_W-1:0]   out_cell_reg;
    logic                out_scroll_reg;

    logic [COL_W-1:0]  new_cols;
    logic [ROW_W-1:0]  new_rows;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] wchar;
    logic [LIN_W-1:0]  cur_lin;
    logic [LIN_W-1:0]  rd_lin;
    logic [LIN_W-1:0]  total;
    logic [LIN_W-1:0]  copy_end;
    logic [LIN_W-1:0]  src_lin;
    logic              scr_copy;
    logic              last_col;
    logic              last_row;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_wdata;

    // zero counts as one, anything above the parameter saturates; rows look only at the low ROW_W bits
    always_comb begin
        if (cfg_wdata == '0) begin
            new_cols = COL_W'(1);
        end else if (cfg_wdata > MAX_COLS) begin
            new_cols = COL_W'(MAX_COLS);
        end else begin
            new_cols = cfg_wdata;
        end
        if (cfg_wdata[ROW_W-1:0] == '0) begin
            new_rows = ROW_W'(1);
        end else if (cfg_wdata[ROW_W-1:0] > MAX_ROWS) begin
            new_rows = ROW_W'(MAX_ROWS);
        end else begin
            new_rows = cfg_wdata[ROW_W-1:0];
        end
    end

    always_comb begin
        if (act_reg == ACT_READ) begin
            kind = KIND_READ;
        end else begin
            unique case (ch_reg)
                CH_NUL:  kind = KIND_NUL;
                CH_TAB:  kind = KIND_TAB;
                CH_LF:   kind = KIND_LF;
                CH_CR:   kind = KIND_CR;
                CH_BS:   kind = KIND_BS;
                default: kind = KIND_CHAR;
            endcase
        end
    end

    assign wchar    = (kind == KIND_TAB || kind == KIND_BS) ? CH_SPACE : ch_reg;
    assign cur_lin  = LIN_W'(row_reg) * LIN_W'(cols_reg) + LIN_W'(col_reg);
    assign rd_lin   = LIN_W'(rr_reg) * LIN_W'(cols_reg) + LIN_W'(rc_reg);
    assign total    = LIN_W'(rows_reg) * LIN_W'(cols_reg);
    assign copy_end = total - LIN_W'(cols_reg);
    // rows above the last copy from one row down, the last row is blanked in place
    assign scr_copy = sa_reg < copy_end;
    assign src_lin  = scr_copy ? (sa_reg + LIN_W'(cols_reg)) : sa_reg;
    assign last_col = col_reg == (cols_reg - COL_W'(1));
    assign last_row = row_reg == (rows_reg - ROW_W'(1));
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RST;
            rows_reg <= ROWS_RST;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCREEN_COLS: begin
                    cols_reg <= new_cols;
                    if (col_reg >= new_cols) begin
                        col_reg <= new_cols - COL_W'(1);
                    end
                end
                REG_SCREEN_ROWS: begin
                    rows_reg <= new_rows;
                    if (row_reg >= new_rows) begin
                        row_reg <= new_rows - ROW_W'(1);
                    end
                end
            endcase
        end else begin
            if (cmd.col_zero) begin
                col_reg <= '0;
            end
            // at the last row the scroll keeps the cursor on that row
            if (cmd.row_inc && !last_row) begin
                row_reg <= row_reg + ROW_W'(1);
            end
            if (cmd.back_step) begin
                if (col_reg == '0) begin
                    if (row_reg != '0) begin
                        col_reg <= cols_reg - COL_W'(1);
                        row_reg <= row_reg - ROW_W'(1);
                    end
                end else begin
                    col_reg <= col_reg - COL_W'(1);
                end
            end
            if (cmd.advance) begin
                if (last_col) begin
                    col_reg <= '0;
                    if (!last_row) begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            sa_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.scroll_start) begin
                sa_reg <= '0;
            end else if (cmd.scroll_wr) begin
                sa_reg <= sa_reg + LIN_W'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            act_reg      <= s_action;
            ch_reg       <= s_char_code;
            fg_reg       <= s_fg_color;
            bg_reg       <= s_bg_color;
            rc_reg       <= s_read_col;
            rr_reg       <= s_read_row;
            cell_reg     <= '0;
            scrolled_reg <= 1'b0;
        end else begin
            if (cmd.cap_cell) begin
                cell_reg <= rdata_reg;
            end
            if (cmd.scroll_start) begin
                scrolled_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
            out_lin_reg    <= cur_lin[LINEAR_W-1:0];
            out_cell_reg   <= cell_reg;
            out_scroll_reg <= scrolled_reg;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(cur_lin);
        mem_wdata = {bg_reg, fg_reg, wchar};
        priority if (cmd.clear_wr) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = BLANK_CELL;
        end else if (cmd.scroll_wr) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(sa_reg);
            mem_wdata = scr_copy ? rdata_reg : {rdata_reg[CELL_W-1:CHAR_W], CH_SPACE};
        end else if (cmd.write_cell) begin
            mem_we = 1'b1;
        end else begin
            mem_we = 1'b0;
        end
    end

    assign mem_raddr = cmd.scroll_rd ? ADDR_W'(src_lin) : ADDR_W'(rd_lin);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= cell_mem[mem_raddr];
    end

    assign status.kind     = kind;
    assign status.rd_ok    = (rc_reg < cols_reg) && (rr_reg < rows_reg);
    assign status.last_col = last_col;
    assign status.last_row = last_row;
    assign status.clr_last = clr_addr_reg == ADDR_W'(DEPTH - 1);
    assign status.scr_last = sa_reg == (total - LIN_W'(1));
    assign status.out_free = out_free;

    assign m_valid         = m_valid_reg;
    assign m_cursor_col    = out_col_reg;
    assign m_cursor_row    = out_row_reg;
    assign m_cursor_linear = out_lin_reg;
    assign m_cell_value    = out_cell_reg;
    assign m_did_scroll    = out_scroll_reg;

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < cols_reg) && (row_reg < rows_reg))
        else $error("cursor outside the screen geometry");
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("output word overwritten before it was taken");
    a_scroll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scroll_wr |-> (sa_reg < total))
        else $error("scroll sweep ran past the screen");
`endif

endmodule
`default_nettype wire

@@ src/tcce_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer of the text console: clearing pass, item decode, cell writes,
// tab expansion, scroll sweep and hand-off to the output word register.
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire tcce_pkg::tcce_status_t status,
    output tcce_pkg::tcce_cmd_t         cmd
);
    import tcce_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_EXEC   = 4'd2;
    localparam logic [3:0] S_RDWAIT = 4'd3;
    localparam logic [3:0] S_PUT    = 4'd4;
    localparam logic [3:0] S_BLANK  = 4'd5;
    localparam logic [3:0] S_SCRRD  = 4'd6;
    localparam logic [3:0] S_SCRWR  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [TAB_W-1:0] tab_reg;
    logic [TAB_W-1:0] tab_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            tab_reg   <= '0;
        end else begin
            state_reg <= state_next;
            tab_reg   <= tab_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        tab_next   = tab_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (status.kind)
                    KIND_READ: begin
                        state_next = status.rd_ok ? S_RDWAIT : S_DONE;
                    end
                    KIND_NUL: begin
                        state_next = S_DONE;
                    end
                    KIND_CR: begin
                        cmd.col_zero = 1'b1;
                        state_next   = S_DONE;
                    end
                    KIND_LF: begin
                        cmd.row_inc = 1'b1;
                        if (status.last_row) begin
                            cmd.scroll_start = 1'b1;
                            state_next       = S_SCRRD;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    KIND_BS: begin
                        cmd.back_step = 1'b1;
                        state_next    = S_BLANK;
                    end
                    KIND_TAB: begin
                        tab_next   = TAB_W'(TAB_SPACES - 1);
                        state_next = S_PUT;
                    end
                    default: begin
                        state_next = S_PUT;
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.cap_cell = 1'b1;
                state_next   = S_DONE;
            end
            S_PUT: begin
                cmd.write_cell = 1'b1;
                cmd.advance    = 1'b1;
                // wrap off the bottom right corner scrolls before the next space
                if (status.last_col && status.last_row) begin
                    cmd.scroll_start = 1'b1;
                    state_next       = S_SCRRD;
                end else if (tab_reg != '0) begin
                    tab_next = tab_reg - TAB_W'(1);
                end else begin
                    state_next = S_DONE;
                end
            end
            S_BLANK: begin
                cmd.write_cell = 1'b1;
                state_next     = S_DONE;
            end
            S_SCRRD: begin
                cmd.scroll_rd = 1'b1;
                state_next    = S_SCRWR;
            end
            S_SCRWR: begin
                cmd.scroll_wr = 1'b1;
                if (status.scr_last) begin
                    if (tab_reg != '0) begin
                        tab_next   = tab_reg - TAB_W'(1);
                        state_next = S_PUT;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_SCRRD;
                end
            end
            S_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_wr, cmd.scroll_wr, cmd.write_cell}))
        else $error("more than one cell write source in a cycle");
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_EXEC))
        else $error("accepted word not decoded next cycle");
    a_tab_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (tab_reg == '0))
        else $error("tab spaces left over at idle");
`endif

endmodule
`default_nettype wire

@@ src/text_console_char_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_char_engine
// After reset the engine runs a clearing pass over all MAX_COLS*MAX_ROWS
// cells (2000 by default) that fills the cell memory with grey-on-black
// spaces, with s_ready low. Then the sequencer takes each word from decode
// to the result state: a read on the screen waits for the memory read in
// between, a plain character writes its cell and a backspace steps back and
// writes a blank; NUL, CR, a line feed that does not scroll and a read off
// the screen go straight to the result state, and a tab writes its four
// spaces one after another. A scroll reads and writes each screen cell once,
// in alternating read and write states. A result waits in an output
// register; the next word is accepted as soon as the sequencer is back at
// idle, which it reaches only once the previous result has been taken into
// that register. Geometry writes on the cfg port take effect at once and
// clamp the cursor.
// ----------------------------------------------------------------------------
module text_console_char_engine #(
    parameter int unsigned MAX_COLS = tcce_pkg::MAX_COLS_DEF,
    parameter int unsigned MAX_ROWS = tcce_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcce_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [tcce_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcce_pkg::COLOR_W-1:0]    s_fg_color,
    input  wire logic [tcce_pkg::COLOR_W-1:0]    s_bg_color,
    input  wire logic [tcce_pkg::COL_W-1:0]      s_read_col,
    input  wire logic [tcce_pkg::ROW_W-1:0]      s_read_row,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tcce_pkg::COL_W-1:0]           m_cursor_col,
    output logic [tcce_pkg::ROW_W-1:0]           m_cursor_row,
    output logic [tcce_pkg::LINEAR_W-1:0]        m_cursor_linear,
    output logic [tcce_pkg::CELL_W-1:0]          m_cell_value,
    output logic                                 m_did_scroll
);
    import tcce_pkg::*;

    tcce_cmd_t    cmd;
    tcce_status_t status;

    tcce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcce_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_action        (s_action),
        .s_char_code     (s_char_code),
        .s_fg_color      (s_fg_color),
        .s_bg_color      (s_bg_color),
        .s_read_col      (s_read_col),
        .s_read_row      (s_read_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_value    (m_cell_value),
        .m_did_scroll    (m_did_scroll),
        .cmd             (cmd),
        .status          (status)
    );

endmodule
`default_nettype wire

@@ sim/tcce_cursor_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_cursor_monitor
// Watches the geometry port and both word channels of the console engine.
// It keeps its own screen memory, cursor and geometry, works out the cursor
// report for every accepted input word and compares each result word with
// the oldest report still due, field by field.
// ----------------------------------------------------------------------------
module tcce_cursor_monitor (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tcce_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                            s_valid,
    input  wire logic                            s_ready,
    input  wire logic                            s_action,
    input  wire logic [tcce_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [tcce_pkg::COLOR_W-1:0]    s_fg_color,
    input  wire logic [tcce_pkg::COLOR_W-1:0]    s_bg_color,
    input  wire logic [tcce_pkg::COL_W-1:0]      s_read_col,
    input  wire logic [tcce_pkg::ROW_W-1:0]      s_read_row,
    input  wire logic                            m_valid,
    input  wire logic                            m_ready,
    input  wire logic [tcce_pkg::COL_W-1:0]      m_cursor_col,
    input  wire logic [tcce_pkg::ROW_W-1:0]      m_cursor_row,
    input  wire logic [tcce_pkg::LINEAR_W-1:0]   m_cursor_linear,
    input  wire logic [tcce_pkg::CELL_W-1:0]     m_cell_value,
    input  wire logic                            m_did_scroll,
    output int unsigned                          mismatches,
    output int unsigned                          reports_waiting
);
    import tcce_pkg::*;

    localparam int unsigned SCREEN_CELLS = MAX_COLS_DEF * MAX_ROWS_DEF;

    typedef struct packed {
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
        logic [LINEAR_W-1:0] linear;
        logic [CELL_W-1:0]   cell_value;
        logic                scrolled;
    } cursor_report_t;

    logic [CELL_W-1:0] screen_mem [SCREEN_CELLS];
    int unsigned       col_now;
    int unsigned       row_now;
    logic [COL_W-1:0]  cols_reg;
    logic [ROW_W-1:0]  rows_reg;
    bit                scrolled_now;
    int unsigned       results_seen;
    cursor_report_t    cursor_reports_due [$];

    // out-of-range register values saturate to 1 or to the maximum
    function automatic int unsigned cols_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
        return 32'(cols_reg);
    endfunction

    function automatic int unsigned rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
        return 32'(rows_reg);
    endfunction

    function automatic void clamp_cursor();
        if (col_now >= cols_in_use()) col_now = cols_in_use() - 1;
        if (row_now >= rows_in_use()) row_now = rows_in_use() - 1;
    endfunction

    function automatic int unsigned screen_index(input int unsigned x, input int unsigned y);
        int unsigned a;
        a = y * cols_in_use() + x;
        return (a < SCREEN_CELLS) ? a : 0;
    endfunction

    function automatic void store_glyph(input logic [CHAR_W-1:0] ch,
                                        input logic [COLOR_W-1:0] fg,
                                        input logic [COLOR_W-1:0] bg);
        screen_mem[screen_index(col_now, row_now)] = {bg, fg, ch};
    endfunction

    // every row moves up; the last row turns to spaces but keeps its colors
    function automatic void scroll_screen();
        int unsigned nc;
        int unsigned nr;
        int unsigned a;
        nc = cols_in_use();
        nr = rows_in_use();
        for (int unsigned y = 0; y + 1 < nr; y++)
            for (int unsigned x = 0; x < nc; x++)
                screen_mem[screen_index(x, y)] = screen_mem[screen_index(x, y + 1)];
        for (int unsigned x = 0; x < nc; x++) begin
            a = screen_index(x, nr - 1);
            screen_mem[a] = {screen_mem[a][CELL_W-1:CHAR_W], CH_SPACE};
        end
        row_now = nr - 1;
    endfunction

    function automatic void line_down();
        row_now++;
        if (row_now >= rows_in_use()) begin
            scroll_screen();
            scrolled_now = 1'b1;
        end
    endfunction

    function automatic void put_glyph(input logic [CHAR_W-1:0] ch,
                                      input logic [COLOR_W-1:0] fg,
                                      input logic [COLOR_W-1:0] bg);
        store_glyph(ch, fg, bg);
        col_now++;
        if (col_now >= cols_in_use()) begin
            line_down();
            col_now = 0;
        end
    endfunction

    function automatic cursor_report_t predict_cursor_report(
        input logic               act,
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input logic [COL_W-1:0]   rc,
        input logic [ROW_W-1:0]   rr
    );
        cursor_report_t    rep;
        logic [CELL_W-1:0] cell_word;
        int unsigned       lin;
        cell_word    = '0;
        scrolled_now = 1'b0;
        clamp_cursor();
        if (act == ACT_READ) begin
            if (rc < cols_in_use() && rr < rows_in_use())
                cell_word = screen_mem[screen_index(32'(rc), 32'(rr))];
        end else begin
            case (ch)
                CH_NUL: ;
                CH_TAB: repeat (TAB_SPACES) put_glyph(CH_SPACE, fg, bg);
                CH_LF:  line_down();
                CH_CR:  col_now = 0;
                CH_BS: begin
                    // at column 0 step to the end of the row above, if any
                    if (col_now == 0) begin
                        if (row_now > 0) begin
                            col_now = cols_in_use() - 1;
                            row_now--;
                        end
                    end else begin
                        col_now--;
                    end
                    store_glyph(CH_SPACE, fg, bg);
                end
                default: put_glyph(ch, fg, bg);
            endcase
        end
        lin            = row_now * cols_in_use() + col_now;
        rep.col        = col_now[COL_W-1:0];
        rep.row        = row_now[ROW_W-1:0];
        rep.linear     = lin[LINEAR_W-1:0];
        rep.cell_value = cell_word;
        rep.scrolled   = scrolled_now;
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: result word %0d: %s got 0x%0h, wanted 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cursor_report_t want;
        if (!aresetn) begin
            for (int unsigned i = 0; i < SCREEN_CELLS; i++) screen_mem[i] = BLANK_CELL;
            col_now  = 0;
            row_now  = 0;
            cols_reg = COL_W'(SCREEN_COLS_RESET);
            rows_reg = ROW_W'(SCREEN_ROWS_RESET);
            cursor_reports_due.delete();
            results_seen    = 0;
            mismatches      = 0;
            reports_waiting = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (cursor_reports_due.size() == 0) begin
                    report_mismatch("word with nothing pending", 0, 0);
                end else begin
                    want = cursor_reports_due.pop_front();
                    if (m_cursor_col !== want.col)
                        report_mismatch("cursor_col", 32'(m_cursor_col), 32'(want.col));
                    if (m_cursor_row !== want.row)
                        report_mismatch("cursor_row", 32'(m_cursor_row), 32'(want.row));
                    if (m_cursor_linear !== want.linear)
                        report_mismatch("cursor_linear", 32'(m_cursor_linear),
                                        32'(want.linear));
                    if (m_cell_value !== want.cell_value)
                        report_mismatch("cell_value", 32'(m_cell_value),
                                        32'(want.cell_value));
                    if (m_did_scroll !== want.scrolled)
                        report_mismatch("did_scroll", 32'(m_did_scroll), 32'(want.scrolled));
                end
                results_seen++;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCREEN_COLS: cols_reg = cfg_wdata;
                    REG_SCREEN_ROWS: rows_reg = cfg_wdata[ROW_W-1:0];
                    default: ;
                endcase
                clamp_cursor();
            end
            if (s_valid && s_ready)
                cursor_reports_due.push_back(predict_cursor_report(
                    s_action, s_char_code, s_fg_color, s_bg_color, s_read_col, s_read_row));
            reports_waiting = cursor_reports_due.size();
        end
    end

endmodule

@@ sim/tb_text_console_char_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_engine
// Drives the console engine with a short directed run (reset contents,
// out-of-range reads, every control code, high bytes, wrap and scroll) and
// then random words under many screen geometries, including zero and
// oversized register values, with random idling on both channels. The cursor
// monitor beside the engine predicts and checks every result word.
// ----------------------------------------------------------------------------
module tb_text_console_char_engine;
    import tcce_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 20_000_000;
    localparam int unsigned TAIL_CYCLES    = 100;
    localparam int unsigned HEAVY_IDLE_PCT = 69;
    localparam int unsigned LIGHT_IDLE_PCT = 9;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = REG_SCREEN_COLS;
    logic [CFG_W-1:0]     cfg_wdata   = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic                 s_action    = ACT_PUT;
    logic [CHAR_W-1:0]    s_char_code = CH_NUL;
    logic [COLOR_W-1:0]   s_fg_color  = '0;
    logic [COLOR_W-1:0]   s_bg_color  = '0;
    logic [COL_W-1:0]     s_read_col  = '0;
    logic [ROW_W-1:0]     s_read_row  = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [COL_W-1:0]     m_cursor_col;
    logic [ROW_W-1:0]     m_cursor_row;
    logic [LINEAR_W-1:0]  m_cursor_linear;
    logic [CELL_W-1:0]    m_cell_value;
    logic                 m_did_scroll;

    int unsigned mismatches;
    int unsigned reports_waiting;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned cycle_count = 0;

    text_console_char_engine dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_code     (s_char_code),
        .s_fg_color      (s_fg_color),
        .s_bg_color      (s_bg_color),
        .s_read_col      (s_read_col),
        .s_read_row      (s_read_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_value    (m_cell_value),
        .m_did_scroll    (m_did_scroll)
    );

    tcce_cursor_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_code     (s_char_code),
        .s_fg_color      (s_fg_color),
        .s_bg_color      (s_bg_color),
        .s_read_col      (s_read_col),
        .s_read_row      (s_read_row),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_value    (m_cell_value),
        .m_did_scroll    (m_did_scroll),
        .mismatches      (mismatches),
        .reports_waiting (reports_waiting)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d result words still due",
                     cycle_count, reports_waiting);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [CHAR_W-1:0] ch,
                             input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                             input logic [COL_W-1:0] rc, input logic [ROW_W-1:0] rr);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_char_code <= ch;
        s_fg_color  <= fg;
        s_bg_color  <= bg;
        s_read_col  <= rc;
        s_read_row  <= rr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_waiting != 0) @(negedge aclk);
    endtask

    task automatic write_geometry(input logic [CFG_W-1:0] cols_w,
                                  input logic [CFG_W-1:0] rows_w);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCREEN_COLS;
        cfg_wdata <= cols_w;
        @(negedge aclk);
        cfg_index <= REG_SCREEN_ROWS;
        cfg_wdata <= rows_w;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // reads mostly land on the visible screen; NUL puts do not count as words
    task automatic random_word(input int unsigned ncols, input int unsigned nrows,
                               output bit counted);
        logic               act;
        logic [CHAR_W-1:0]  ch;
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic [COL_W-1:0]   rc;
        logic [ROW_W-1:0]   rr;
        int unsigned        pick;
        act  = ACT_PUT;
        ch   = CHAR_W'($urandom);
        fg   = COLOR_W'($urandom);
        bg   = COLOR_W'($urandom);
        rc   = COL_W'($urandom);
        rr   = ROW_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 15) begin
            act = ACT_READ;
            if ($urandom_range(3) != 0) begin
                rc = COL_W'($urandom_range(ncols - 1));
                rr = ROW_W'($urandom_range(nrows - 1));
            end
        end else if (pick < 18) begin
            ch = CH_NUL;
        end else if (pick < 24) begin
            ch = CH_TAB;
        end else if (pick < 38) begin
            ch = CH_LF;
        end else if (pick < 43) begin
            ch = CH_CR;
        end else if (pick < 50) begin
            ch = CH_BS;
        end
        counted = !(act == ACT_PUT && ch == CH_NUL);
        send_word(act, ch, fg, bg, rc, rr);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cols_w, input logic [CFG_W-1:0] rows_w,
                             input int unsigned words, input idle_mode_t mode);
        int unsigned ncols;
        int unsigned nrows;
        int unsigned taken;
        bit          counted;
        wait_results_drained();
        write_geometry(cols_w, rows_w);
        ncols = (cols_w == 0) ? 1 : ((cols_w > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_w);
        nrows = (rows_w[ROW_W-1:0] == 0) ? 1 :
                ((rows_w[ROW_W-1:0] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_w[ROW_W-1:0]);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;              stall_pct = 0;              end
            IDLE_SENDER:   begin gap_pct = HEAVY_IDLE_PCT; stall_pct = 0;              end
            IDLE_RECEIVER: begin gap_pct = 0;              stall_pct = HEAVY_IDLE_PCT; end
            default:       begin gap_pct = LIGHT_IDLE_PCT; stall_pct = LIGHT_IDLE_PCT; end
        endcase
        taken = 0;
        while (taken < words) begin
            random_word(ncols, nrows, counted);
            if (counted) taken++;
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset screen, corners and reads off the screen
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd0, 5'd0);
        send_word(ACT_READ, 8'hFF, 4'hF, 4'hF, 7'd79, 5'd24);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd80, 5'd0);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd0, 5'd25);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd127, 5'd31);
        // control codes and high bytes at full size
        send_word(ACT_PUT, CH_NUL, 4'h1, 4'h2, 7'd0, 5'd0);
        send_word(ACT_PUT, 8'h41, 4'hF, 4'h0, 7'd0, 5'd0);
        send_word(ACT_PUT, 8'hFF, 4'h0, 4'hF, 7'd127, 5'd31);
        send_word(ACT_PUT, 8'h80, 4'h9, 4'h6, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_BS, 4'h3, 4'h5, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_CR, 4'h0, 4'h0, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_BS, 4'hA, 4'h1, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_TAB, 4'h2, 4'h6, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_LF, 4'h0, 4'h0, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_CR, 4'h0, 4'h0, 7'd0, 5'd0);
        // backspace from column 0 climbs to the end of the row above
        send_word(ACT_PUT, CH_BS, 4'hC, 4'h4, 7'd0, 5'd0);
        send_word(ACT_PUT, 8'h7E, 4'hE, 4'h8, 7'd0, 5'd0);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd79, 5'd0);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd0, 5'd0);

        // tiny screen so wraps scroll right away
        wait_results_drained();
        write_geometry(7'd3, 7'd2);
        send_word(ACT_PUT, 8'h78, 4'h1, 4'h7, 7'd0, 5'd0);
        send_word(ACT_PUT, 8'h79, 4'h2, 4'h8, 7'd0, 5'd0);
        send_word(ACT_PUT, 8'h7A, 4'h3, 4'h9, 7'd0, 5'd0);
        send_word(ACT_PUT, CH_TAB, 4'h4, 4'hA, 7'd0, 5'd0);
        send_word(ACT_READ, CH_NUL, 4'h0, 4'h0, 7'd0, 5'd1);

        run_phase(7'd80, 7'd25, 150, IDLE_NONE);
        run_phase(7'd1, 7'd1, 70, IDLE_SENDER);
        run_phase(7'd1, 7'd25, 70, IDLE_RECEIVER);
        run_phase(7'd80, 7'd1, 90, IDLE_BOTH);
        run_phase(7'd0, 7'd0, 50, IDLE_NONE);
        run_phase(7'd7, 7'd3, 140, IDLE_SENDER);
        run_phase(7'd16, 7'd6, 140, IDLE_RECEIVER);
        run_phase(7'd127, 7'd127, 130, IDLE_BOTH);
        run_phase(7'd40, 7'd12, 120, IDLE_NONE);
        run_phase(7'd2, 7'd24, 80, IDLE_SENDER);
        run_phase(7'd81, 7'd26, 60, IDLE_RECEIVER);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
